@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/snu_pkg.sv @@
// Types, constants and fixed-point helpers for the neuron update block.
package snu_pkg;

  localparam int IDX_W      = 10;
  localparam int IDX_SPAN   = 1 << IDX_W;
  localparam int Q_W        = 32;
  localparam int DEC_W      = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [63:0]    p64_t;
  typedef logic signed [39:0]    acc_t;

  localparam q_t ONE_Q = 32'sh0100_0000;

  typedef enum logic [1:0] {
    GM_GATED  = 2'd0,
    GM_STATIC = 2'd1,
    GM_NONE   = 2'd2
  } gain_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_MODE       = 3'd0,
    CFG_RECOVERY_GAIN   = 3'd1,
    CFG_CUBIC_ROOT      = 3'd2,
    CFG_RESET_DROP      = 3'd3,
    CFG_DROP_THRESHOLD  = 3'd4,
    CFG_RECOVERY_TARGET = 3'd5,
    CFG_RATE_DECAY      = 3'd6,
    CFG_TRACE_DECAY     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] neuron_index;
    q_t               synaptic_current;
    q_t               eps_offset;
  } snu_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    q_t               membrane_out;
    q_t               rate_out;
    logic             spike;
  } snu_out_t;

  // One memory word holds the whole per-neuron state.
  typedef struct packed {
    q_t membrane;
    q_t recovery;
    q_t syn_rate;
    q_t syn_trace;
  } state_word_t;

  function automatic q_t sat32(input acc_t x);
    if (x[39:31] == '0 || x[39:31] == '1) begin
      return x[31:0];
    end else if (x[39]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // Q8.24 product: round half up, drop 24 fraction bits, saturate.
  function automatic q_t qmul_rnd(input p64_t p);
    p64_t t;
    t = p + 64'sd8388608;
    return sat32(t[63:24]);
  endfunction

endpackage

@@ hdl/snu_state_ram.sv @@
// Per-neuron state memory: one write port, one registered read port.
module snu_state_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  snu_pkg::state_word_t  wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output snu_pkg::state_word_t  rd_data
);
  import snu_pkg::*;

  state_word_t mem_r [DEPTH];
  state_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read-before-write on a shared address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/spiking_neuron_synapse_update_top.sv @@
// Neuron update top: seven-stage FitzHugh-Nagumo step with per-neuron state RAM.
// An accepted word passes stage registers S1..S7 and then the output register that drives out_valid.
// Throughput: one word per cycle when nothing stalls; state is read-modify-write, so a word for a neuron still in
// stages 1..7 waits for that neuron's write-back, which an output stall can delay further.
// Reset: synchronous, active low; then a clearing pass zeroes each of the min(N_NEURONS, 1024)
// state RAM entries, with in_ready low. Config writes are taken throughout.
`include "assert_macros.svh"

module spiking_neuron_synapse_update_top #(
  parameter int N_NEURONS      = 1024,
  parameter int SPIKE_LEVEL    = 8388608,
  parameter int EPS_GATE_LEVEL = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  snu_pkg::snu_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output snu_pkg::snu_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [snu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snu_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import snu_pkg::*;

  // Only the first 1024 neurons are addressable by a 10-bit index.
  localparam int DEPTH = (N_NEURONS < IDX_SPAN) ? N_NEURONS : IDX_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NST   = 7;

  // ---------------------------------------------------------------------
  // Stage payloads. Each stage carries its index and an in-range flag;
  // out-of-range words flow through but never write back.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    q_t               syn;
    q_t               eoff;
  } s1_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    q_t v, cur, r, h, syn, drop_sel;
    q_t gain, d1, a, b;
  } s2_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    q_t v, cur, r, h, syn, drop_sel;
    p64_t                      p_rec;
    p64_t                      p_ab;
    logic signed [57:0]        p_r;
    logic signed [57:0]        p_h;
    logic [2*DEC_W-1:0]        p_k;
  } s3_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    q_t v, cur, r, h, syn, drop_sel;
    q_t q_rec, m1, q_r, q_h, q_k;
  } s4_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    p64_t p_v;
    acc_t vpart;
    acc_t hpart;
    q_t   rec_new, rn, q_k;
  } s5_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    q_t   m2;
    acc_t vpart;
    acc_t hpart;
    q_t   rec_new, rn, q_k;
  } s6_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
    q_t   vnew;
    logic spike;
    acc_t hpart;
    q_t   rec_new, rn, q_k;
  } s7_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0]       mode_r;
  q_t               gain0_r, croot_r, drop_r, dthr_r, target_r;
  logic [DEC_W-1:0] rdec_r, tdec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= GM_NONE;
      gain0_r  <= '0;
      croot_r  <= '0;
      drop_r   <= '0;
      dthr_r   <= '0;
      target_r <= '0;
      rdec_r   <= '0;
      tdec_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_MODE:       mode_r   <= cfg_data[1:0];
        CFG_RECOVERY_GAIN:   gain0_r  <= cfg_data;
        CFG_CUBIC_ROOT:      croot_r  <= cfg_data;
        CFG_RESET_DROP:      drop_r   <= cfg_data;
        CFG_DROP_THRESHOLD:  dthr_r   <= cfg_data;
        CFG_RECOVERY_TARGET: target_r <= cfg_data;
        CFG_RATE_DECAY:      rdec_r   <= cfg_data[DEC_W-1:0];
        CFG_TRACE_DECAY:     tdec_r   <= cfg_data[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: per-stage valid bits, ready ripples back so bubbles collapse
  // ---------------------------------------------------------------------
  logic [NST:1]   vld_r, vld_nxt;
  logic [NST+1:1] rdy;
  logic           out_valid_r, out_valid_nxt;
  logic           hazard, acc, in_ok;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;
  s7_t s7_r, s7_nxt;
  snu_out_t out_data_r, out_data_nxt;

  always_comb begin
    rdy[NST+1] = !out_valid_r || out_ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // In-flight neurons that have not written back yet.
  logic [IDX_W-1:0] fl_idx [1:NST];
  logic             fl_ok  [1:NST];

  assign fl_idx[1] = s1_r.idx;  assign fl_ok[1] = s1_r.ok;
  assign fl_idx[2] = s2_r.idx;  assign fl_ok[2] = s2_r.ok;
  assign fl_idx[3] = s3_r.idx;  assign fl_ok[3] = s3_r.ok;
  assign fl_idx[4] = s4_r.idx;  assign fl_ok[4] = s4_r.ok;
  assign fl_idx[5] = s5_r.idx;  assign fl_ok[5] = s5_r.ok;
  assign fl_idx[6] = s6_r.idx;  assign fl_ok[6] = s6_r.ok;
  assign fl_idx[7] = s7_r.idx;  assign fl_ok[7] = s7_r.ok;

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= NST; k++) begin
      if (vld_r[k] && fl_ok[k] && (fl_idx[k] == in_data.neuron_index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_ok    = 32'(in_data.neuron_index) < N_NEURONS;
  assign in_ready = rdy[1] && !clr_r && !hazard;
  assign acc      = in_valid && in_ready;

  always_comb begin
    vld_nxt[1] = rdy[1] ? acc : vld_r[1];
    for (int k = 2; k <= NST; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    out_valid_nxt = rdy[NST+1] ? vld_r[NST] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // State memory
  // ---------------------------------------------------------------------
  state_word_t   rd_word, wb_word, wr_word;
  logic          wb_en, wr_en;
  logic [AW-1:0] wr_addr;

  assign wb_en   = vld_r[NST] && rdy[NST+1] && s7_r.ok;
  assign wr_en   = clr_r || wb_en;
  assign wr_addr = clr_r ? clr_cnt_r : s7_r.idx[AW-1:0];
  assign wr_word = clr_r ? '0 : wb_word;

  snu_state_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (acc),
    .rd_addr (in_data.neuron_index[AW-1:0]),
    .rd_data (rd_word)
  );

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  // S1: capture word, RAM read in flight
  always_comb begin
    s1_nxt.idx  = in_data.neuron_index;
    s1_nxt.ok   = in_ok;
    s1_nxt.syn  = in_data.synaptic_current;
    s1_nxt.eoff = in_data.eps_offset;
  end

  // S2: gain select, offsets against v, drop select
  logic gate;
  always_comb begin
    gate = (mode_r == GM_STATIC) ||
           ((mode_r == GM_GATED) && (rd_word.membrane > EPS_GATE_LEVEL));
    s2_nxt.idx      = s1_r.idx;
    s2_nxt.ok       = s1_r.ok;
    s2_nxt.v        = rd_word.membrane;
    s2_nxt.cur      = rd_word.recovery;
    s2_nxt.r        = rd_word.syn_rate;
    s2_nxt.h        = rd_word.syn_trace;
    s2_nxt.syn      = s1_r.syn;
    s2_nxt.drop_sel = (rd_word.membrane > dthr_r) ? drop_r : '0;
    s2_nxt.gain     = gate ? sat32(40'(gain0_r) + 40'(s1_r.eoff)) : gain0_r;
    s2_nxt.d1       = sat32(40'(rd_word.membrane) - 40'(target_r));
    s2_nxt.a        = sat32(40'(rd_word.membrane) - 40'(croot_r));
    s2_nxt.b        = sat32(40'(ONE_Q) - 40'(rd_word.membrane));
  end

  // S3: first multiplier bank
  always_comb begin
    s3_nxt.idx      = s2_r.idx;
    s3_nxt.ok       = s2_r.ok;
    s3_nxt.v        = s2_r.v;
    s3_nxt.cur      = s2_r.cur;
    s3_nxt.r        = s2_r.r;
    s3_nxt.h        = s2_r.h;
    s3_nxt.syn      = s2_r.syn;
    s3_nxt.drop_sel = s2_r.drop_sel;
    s3_nxt.p_rec    = s2_r.gain * s2_r.d1;
    s3_nxt.p_ab     = s2_r.a * s2_r.b;
    s3_nxt.p_r      = s2_r.r * $signed({1'b0, rdec_r});
    s3_nxt.p_h      = s2_r.h * $signed({1'b0, tdec_r});
    s3_nxt.p_k      = rdec_r * tdec_r;
  end

  // S4: round and saturate the products
  always_comb begin
    s4_nxt.idx      = s3_r.idx;
    s4_nxt.ok       = s3_r.ok;
    s4_nxt.v        = s3_r.v;
    s4_nxt.cur      = s3_r.cur;
    s4_nxt.r        = s3_r.r;
    s4_nxt.h        = s3_r.h;
    s4_nxt.syn      = s3_r.syn;
    s4_nxt.drop_sel = s3_r.drop_sel;
    s4_nxt.q_rec    = qmul_rnd(s3_r.p_rec);
    s4_nxt.m1       = qmul_rnd(s3_r.p_ab);
    s4_nxt.q_r      = qmul_rnd(64'(s3_r.p_r));
    s4_nxt.q_h      = qmul_rnd(64'(s3_r.p_h));
    s4_nxt.q_k      = qmul_rnd(64'(s3_r.p_k));
  end

  // S5: cubic second multiply; recovery, rate and partial sums
  always_comb begin
    s5_nxt.idx     = s4_r.idx;
    s5_nxt.ok      = s4_r.ok;
    s5_nxt.p_v     = s4_r.v * s4_r.m1;
    s5_nxt.vpart   = 40'(s4_r.v) - 40'(s4_r.drop_sel) - 40'(s4_r.cur) + 40'(s4_r.syn);
    s5_nxt.hpart   = 40'(s4_r.h) - 40'(s4_r.q_h);
    s5_nxt.rec_new = sat32(40'(s4_r.cur) + 40'(s4_r.q_rec));
    s5_nxt.rn      = sat32(40'(s4_r.r) - 40'(s4_r.q_r) + 40'(s4_r.h));
    s5_nxt.q_k     = s4_r.q_k;
  end

  // S6: round the cubic term
  always_comb begin
    s6_nxt.idx     = s5_r.idx;
    s6_nxt.ok      = s5_r.ok;
    s6_nxt.m2      = qmul_rnd(s5_r.p_v);
    s6_nxt.vpart   = s5_r.vpart;
    s6_nxt.hpart   = s5_r.hpart;
    s6_nxt.rec_new = s5_r.rec_new;
    s6_nxt.rn      = s5_r.rn;
    s6_nxt.q_k     = s5_r.q_k;
  end

  // S7: new membrane and spike
  always_comb begin
    s7_nxt.idx     = s6_r.idx;
    s7_nxt.ok      = s6_r.ok;
    s7_nxt.vnew    = sat32(s6_r.vpart + 40'(s6_r.m2));
    s7_nxt.spike   = s7_nxt.vnew > SPIKE_LEVEL;
    s7_nxt.hpart   = s6_r.hpart;
    s7_nxt.rec_new = s6_r.rec_new;
    s7_nxt.rn      = s6_r.rn;
    s7_nxt.q_k     = s6_r.q_k;
  end

  // Output / write-back: trace update needs the spike
  q_t hn;
  always_comb begin
    hn = sat32(s7_r.hpart + (s7_r.spike ? 40'(s7_r.q_k) : 40'sd0));
    wb_word.membrane  = s7_r.vnew;
    wb_word.recovery  = s7_r.rec_new;
    wb_word.syn_rate  = s7_r.rn;
    wb_word.syn_trace = hn;
    out_data_nxt.out_index    = s7_r.idx;
    out_data_nxt.membrane_out = s7_r.ok ? s7_r.vnew : '0;
    out_data_nxt.rate_out     = s7_r.ok ? s7_r.rn : '0;
    out_data_nxt.spike        = s7_r.ok && s7_r.spike;
  end

  // Payload registers: load when the stage takes a new word
  always_ff @(posedge clk) begin
    if (acc)                        s1_r       <= s1_nxt;
    if (rdy[2] && vld_r[1])         s2_r       <= s2_nxt;
    if (rdy[3] && vld_r[2])         s3_r       <= s3_nxt;
    if (rdy[4] && vld_r[3])         s4_r       <= s4_nxt;
    if (rdy[5] && vld_r[4])         s5_r       <= s5_nxt;
    if (rdy[6] && vld_r[5])         s6_r       <= s6_nxt;
    if (rdy[7] && vld_r[6])         s7_r       <= s7_nxt;
    if (rdy[NST+1] && vld_r[NST])   out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Clearing pass and write-back never share the write port.
  `ASSERT_NEVER(a_clr_vs_wb, clk, rst_n, clr_r && wb_en)
  // A word never reads a neuron whose write-back lands on the same edge.
  `ASSERT_NEVER(a_rd_wr_same, clk, rst_n, acc && in_ok && wb_en && (s7_r.idx == in_data.neuron_index))
  // The clearing pass ends only after the last entry.
  `ASSERT_CLK(a_clr_end, clk, rst_n, $fell(clr_r) |-> ($past(clr_cnt_r) == AW'(DEPTH - 1)))

endmodule
